FILE: src/dq_pkg.sv
package dq_pkg;

  localparam int WORD_W = 32;
  localparam int OP_W   = 3;
  localparam int CAP_W  = 5;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef logic [WORD_W-1:0] word_t;

  // broadcast to every cell; at most one bit set per cycle
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cell_ctrl_t;

endpackage

FILE: src/dq_cell.sv
module dq_cell import dq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  word_t      push_word,
  input  word_t      left_word,
  input  logic       left_occ,
  input  word_t      right_word,
  input  logic       right_occ,
  output word_t      word,
  output logic       occ,
  output logic       last
);

  word_t word_r, word_nxt;
  logic  occ_r, occ_nxt;

  assign word = word_r;
  assign occ  = occ_r;
  assign last = occ_r & ~right_occ;

  always_comb begin
    word_nxt = word_r;
    occ_nxt  = occ_r;
    if (ctrl.push_front) begin
      // whole row moves one step toward the rear
      word_nxt = left_word;
      occ_nxt  = left_occ;
    end else if (ctrl.pop_front) begin
      word_nxt = right_word;
      occ_nxt  = right_occ;
    end else if (ctrl.push_rear && !occ_r && left_occ) begin
      // first free cell takes the word
      word_nxt = push_word;
      occ_nxt  = 1'b1;
    end else if (ctrl.pop_rear && last) begin
      occ_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

endmodule

FILE: src/bounded_double_ended_queue_top.sv
// Bounded deque built as a row of cells, front entry in cell 0.
// An accepted transaction updates the cell row; its result is registered from the updated
// row once the result register is free or draining.
// No new transaction is taken while the evaluation that reads the updated cell row to form
// front and rear values is pending.
// Reset (rst_n low, synchronous): queue empty, count zero, capacity 16, no result pending.
// Cell words are not reset; an empty cell is never read.
module bounded_double_ended_queue_top import dq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_operation,
  input  logic signed [WORD_W-1:0] in_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_accepted,
  output logic signed [WORD_W-1:0] out_front_value,
  output logic signed [WORD_W-1:0] out_rear_value,
  output logic                     out_is_empty,
  output logic                     out_is_full,
  // capacity register write
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CAP_W-1:0]         cfg_capacity
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // ---------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------
  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             eval_r, eval_nxt;   // cells updated, result being formed
  logic             ok_r, ok_nxt;       // accepted flag of the pending transaction

  logic             in_fire;
  logic             load_out;

  assign cfg_ready = 1'b1;
  assign in_stall  = eval_r;
  assign in_fire   = in_valid & ~in_stall;

  // Capacity saturates at DEPTH; compare at a common width.
  logic [CMP_W-1:0] cap_cmp, eff_cap, count_cmp;
  logic             can_push, can_pop;

  assign cap_cmp   = CMP_W'(cap_r);
  assign eff_cap   = (cap_cmp > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_cmp;
  assign count_cmp = CMP_W'(count_r);
  assign can_push  = count_cmp < eff_cap;
  assign can_pop   = count_r != '0;

  cell_ctrl_t ctrl;

  always_comb begin
    ctrl      = '0;
    ok_nxt    = ok_r;
    count_nxt = count_r;
    if (in_fire) begin
      ok_nxt = 1'b0;
      case (in_operation)
        OP_PUSH_FRONT: begin
          if (can_push) begin
            ctrl.push_front = 1'b1;
            count_nxt       = count_r + CNT_W'(1);
            ok_nxt          = 1'b1;
          end
        end
        OP_PUSH_REAR: begin
          if (can_push) begin
            ctrl.push_rear = 1'b1;
            count_nxt      = count_r + CNT_W'(1);
            ok_nxt         = 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (can_pop) begin
            ctrl.pop_front = 1'b1;
            count_nxt      = count_r - CNT_W'(1);
            ok_nxt         = 1'b1;
          end
        end
        OP_POP_REAR: begin
          if (can_pop) begin
            ctrl.pop_rear = 1'b1;
            count_nxt     = count_r - CNT_W'(1);
            ok_nxt        = 1'b1;
          end
        end
        OP_PEEK: begin
          ok_nxt = 1'b1;
        end
        default: begin
          // unused codes behave as a refused peek
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  // Evaluation holds until the result register is free or draining.
  assign load_out = eval_r & (~out_valid | ~out_stall);

  always_comb begin
    eval_nxt = eval_r;
    if (in_fire) begin
      eval_nxt = 1'b1;
    end else if (load_out) begin
      eval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      count_r <= '0;
      eval_r  <= 1'b0;
      ok_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
      count_r <= count_nxt;
      eval_r  <= eval_nxt;
      ok_r    <= ok_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Cell row: cell 0 sees the push word as its left neighbor, the
  // last cell sees an empty right neighbor.
  // ---------------------------------------------------------------
  word_t             cell_word [DEPTH];
  logic [DEPTH-1:0]  cell_occ;
  logic [DEPTH-1:0]  cell_last;
  word_t             push_word;

  assign push_word = word_t'(in_value);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      word_t lw, rw;
      logic  lo, ro;
      if (gi == 0) begin : g_head
        assign lw = push_word;
        assign lo = 1'b1;
      end else begin : g_mid_l
        assign lw = cell_word[gi-1];
        assign lo = cell_occ[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_tail
        assign rw = push_word;
        assign ro = 1'b0;
      end else begin : g_mid_r
        assign rw = cell_word[gi+1];
        assign ro = cell_occ[gi+1];
      end
      dq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .push_word  (push_word),
        .left_word  (lw),
        .left_occ   (lo),
        .right_word (rw),
        .right_occ  (ro),
        .word       (cell_word[gi]),
        .occ        (cell_occ[gi]),
        .last       (cell_last[gi])
      );
    end
  endgenerate

  // ---------------------------------------------------------------
  // Result formation: front is cell 0, rear is the one cell flagged
  // as last occupied (one-hot AND-OR select).
  // ---------------------------------------------------------------
  word_t rear_sel;
  logic  q_empty;

  always_comb begin
    rear_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_sel = rear_sel | (cell_word[i] & {WORD_W{cell_last[i]}});
    end
  end

  assign q_empty = ~cell_occ[0];

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_ok_r;
  logic signed [WORD_W-1:0] out_front_r, out_rear_r;
  logic                     out_empty_r, out_full_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ok_r    <= ok_r;
      out_front_r <= q_empty ? '1 : $signed(cell_word[0]);
      out_rear_r  <= q_empty ? '1 : $signed(rear_sel);
      out_empty_r <= q_empty;
      out_full_r  <= ~can_push;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_ok_r;
  assign out_front_value = out_front_r;
  assign out_rear_value  = out_rear_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'($countones(cell_occ)) == count_r)
    else $error("entry count disagrees with occupied cells");

  a_occ_packed_front: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_occ + DEPTH'(1)) & cell_occ) == '0)
    else $error("occupied cells not packed toward the front");

  a_cells_frozen_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    eval_r && $past(eval_r) |-> $stable(count_r) && $stable(cell_occ))
    else $error("cell row changed while a result was being formed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && !($past(load_out)))
    else $error("result register loaded while stalled");

endmodule

FILE: bench/bounded_double_ended_queue_top_tb.sv
`timescale 1ns / 1ps

module bounded_double_ended_queue_top_tb;
  import dq_pkg::*;

  localparam int RING_SLOTS    = 16;
  localparam int PHASE_COUNT   = 11;
  localparam int PHASE_ITEMS   = 150;
  localparam int HOLD_CYCLES   = 300;
  localparam int PRESSURE_PASS = 1;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int MAX_REPORTS   = 10;

  // One request as offered on the input channel.
  typedef struct {
    logic [OP_W-1:0] op;
    word_t           value;
  } deque_request_t;

  // One result as the block reports it; compared as a whole.
  typedef struct packed {
    logic  accepted;
    word_t front_value;
    word_t rear_value;
    logic  is_empty;
    logic  is_full;
  } deque_reply_t;

  // Clock and reset. Every input starts at a known value.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          in_operation = '0;
  logic signed [WORD_W-1:0] in_value     = '0;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic                     out_accepted;
  logic signed [WORD_W-1:0] out_front_value;
  logic signed [WORD_W-1:0] out_rear_value;
  logic                     out_is_empty;
  logic                     out_is_full;
  logic                     cfg_valid    = 1'b0;
  logic                     cfg_ready;
  logic [CAP_W-1:0]         cfg_capacity = '0;

  bounded_double_ended_queue_top #(.DEPTH(RING_SLOTS)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accepted    (out_accepted),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_capacity    (cfg_capacity)
  );

  // Requests waiting to be offered, and results the block still owes us.
  deque_request_t request_backlog[$];
  deque_reply_t   deque_replies_due[$];

  // Shadow of the deque: ring storage, head/tail slots, count, capacity reg.
  word_t            ring_word [RING_SLOTS];
  logic [3:0]       ring_head   = '0;
  logic [3:0]       ring_tail   = '0;
  logic [4:0]       ring_count  = '0;
  logic [CAP_W-1:0] cap_setting = CAP_RESET;

  int mismatch_count = 0;
  int cycle_count    = 0;

  // Idle control. no_gaps turns off random idling on both sides for the
  // closing stretch; hold_req starts one long receiver hold-off.
  logic no_gaps   = 1'b0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_count = 0;
  logic receiver_hold;

  assign receiver_hold = hold_req && !hold_done;

  // Apply one request to the shadow deque and queue the result it must give.
  // Capacity above the ring size saturates; a capacity below the count keeps
  // the entries but refuses pushes and reports full.
  task automatic model_deque_op(input logic [OP_W-1:0] op, input word_t word);
    deque_reply_t     r;
    logic [CAP_W-1:0] eff_cap;
    logic [3:0]       rear_slot;
    eff_cap = (cap_setting > RING_SLOTS) ? CAP_W'(RING_SLOTS) : cap_setting;
    r = '0;
    case (op)
      OP_PUSH_FRONT: if (ring_count < eff_cap) begin
        ring_head = ring_head - 4'd1;
        ring_word[ring_head] = word;
        ring_count = ring_count + 5'd1;
        r.accepted = 1'b1;
      end
      OP_PUSH_REAR: if (ring_count < eff_cap) begin
        ring_word[ring_tail] = word;
        ring_tail = ring_tail + 4'd1;
        ring_count = ring_count + 5'd1;
        r.accepted = 1'b1;
      end
      OP_POP_FRONT: if (ring_count != 0) begin
        ring_head = ring_head + 4'd1;
        ring_count = ring_count - 5'd1;
        r.accepted = 1'b1;
      end
      OP_POP_REAR: if (ring_count != 0) begin
        ring_tail = ring_tail - 4'd1;
        ring_count = ring_count - 5'd1;
        r.accepted = 1'b1;
      end
      OP_PEEK: r.accepted = 1'b1;
      default: r.accepted = 1'b0;  // spare codes behave as a refused peek
    endcase
    rear_slot = ring_tail - 4'd1;
    if (ring_count == 0) begin
      r.front_value = '1;
      r.rear_value  = '1;
    end else begin
      r.front_value = ring_word[ring_head];
      r.rear_value  = ring_word[rear_slot];
    end
    r.is_empty = (ring_count == 0);
    r.is_full  = (ring_count >= eff_cap);
    deque_replies_due.push_back(r);
  endtask

  task automatic queue_request(input logic [OP_W-1:0] op, input word_t value);
    deque_request_t q;
    q.op    = op;
    q.value = value;
    request_backlog.push_back(q);
  endtask

  // The capacity register is only touched with nothing in flight: backlog
  // empty, input channel quiet, every result back, plus a short settle.
  // Checked mid-cycle so the driver's updates at the edge are settled.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    while (request_backlog.size() != 0 || in_valid || deque_replies_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid    <= 1'b1;
    cfg_capacity <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    cap_setting = cap;
  endtask

  // Capacity per random pass: extremes, saturation, tiny and mid sizes.
  function automatic logic [CAP_W-1:0] phase_capacity(input int p);
    case (p)
      0:       return 5'd31;
      1:       return 5'd16;
      2:       return 5'd1;
      3:       return 5'd17;
      4:       return 5'd8;
      5:       return 5'd0;
      6:       return 5'd4;
      7:       return 5'd2;
      9:       return 5'd16;
      10:      return 5'd12;
      default: return CAP_W'($urandom_range(0, 31));
    endcase
  endfunction

  // Input driver: takes the next request from the backlog once the current
  // transaction is accepted, with random gap bursts in between. A stalled
  // request is held as is. The shadow deque is advanced at acceptance.
  int send_gap = 0;

  always @(posedge clk) begin : request_driver
    deque_request_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        model_deque_op(in_operation, in_value);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!no_gaps && !receiver_hold && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 18) - 1;
          in_valid <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          nxt = request_backlog.pop_front();
          in_valid     <= 1'b1;
          in_operation <= nxt.op;
          in_value     <= nxt.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the monitor just obeys it.
  always @(posedge clk) begin : hold_timer
    if (hold_req && !hold_done) begin
      if (hold_count == HOLD_CYCLES)
        hold_done <= 1'b1;
      else
        hold_count <= hold_count + 1;
    end
  end

  // Result monitor: checks each accepted transaction against the oldest
  // predicted result, then picks the stall for the next cycle.
  int recv_gap = 0;

  always @(posedge clk) begin : reply_monitor
    deque_reply_t want;
    deque_reply_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_accepted, out_front_value, out_rear_value, out_is_empty, out_is_full};
        if (deque_replies_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] result with nothing outstanding: acc=%0b front=%0d rear=%0d",
                     $realtime, got.accepted, $signed(got.front_value),
                     $signed(got.rear_value));
        end else begin
          want = deque_replies_due.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display({"[%0t] mismatch exp acc=%0b front=%0d rear=%0d empty=%0b full=%0b",
                        " | got acc=%0b front=%0d rear=%0d empty=%0b full=%0b"},
                       $realtime, want.accepted, $signed(want.front_value),
                       $signed(want.rear_value), want.is_empty, want.is_full,
                       got.accepted, $signed(got.front_value),
                       $signed(got.rear_value), got.is_empty, got.is_full);
          end
        end
      end
      if (receiver_hold) begin
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(1, 18) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    int push_pct;
    int r;
    word_t w;
    logic [OP_W-1:0] op;

    foreach (ring_word[i]) ring_word[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset capacity: pops on an empty deque, the spare op codes, extreme words
    // at both ends and a peek, then drain from both sides.
    queue_request(OP_POP_FRONT, 32'h0);
    queue_request(OP_POP_REAR, 32'h0);
    for (int k = OP_PEEK + 1; k < (1 << OP_W); k++)
      queue_request(OP_W'(k), 32'h5A5A_A5A5);
    queue_request(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    queue_request(OP_PUSH_REAR, 32'h8000_0000);
    queue_request(OP_PEEK, 32'hFFFF_FFFF);
    queue_request(OP_POP_FRONT, 32'h0);
    queue_request(OP_POP_REAR, 32'h0);

    // Capacity of one: second push refused, full reported.
    write_capacity(5'd1);
    queue_request(OP_PUSH_REAR, 32'hFFFF_FFFF);
    queue_request(OP_PUSH_FRONT, 32'h0000_0000);

    // Capacity zero with one entry held: push refused, pop still works,
    // then the deque reads both empty and full.
    write_capacity(5'd0);
    queue_request(OP_PUSH_FRONT, 32'h1234_5678);
    queue_request(OP_POP_REAR, 32'h0);
    queue_request(OP_PUSH_REAR, 32'h1234_5678);

    // Capacity dropped below the current count: entries survive, pushes
    // refused, pops go through.
    write_capacity(5'd16);
    for (int k = 0; k < 5; k++)
      queue_request((k % 2) ? OP_PUSH_FRONT : OP_PUSH_REAR, $urandom);
    write_capacity(5'd2);
    queue_request(OP_PUSH_REAR, 32'hDEAD_BEEF);
    queue_request(OP_POP_FRONT, 32'h0);

    // Random passes. Push bias swings every few dozen transactions so the
    // deque keeps hitting both full and empty and the pointers wrap.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_capacity(phase_capacity(p));
      if (p == PRESSURE_PASS) hold_req <= 1'b1;
      if (p == PHASE_COUNT - 1) no_gaps <= 1'b1;
      push_pct = 50;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 24 == 0) begin
          case ($urandom_range(0, 2))
            0:       push_pct = 85;
            1:       push_pct = 50;
            default: push_pct = 15;
          endcase
        end
        r = $urandom_range(0, 99);
        if (r < 3)
          op = OP_W'($urandom_range(OP_PEEK + 1, (1 << OP_W) - 1));
        else if (r < 8)
          op = OP_PEEK;
        else if ($urandom_range(0, 99) < push_pct)
          op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
        else
          op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
        case ($urandom_range(0, 15))
          0:       w = 32'h8000_0000;
          1:       w = 32'h7FFF_FFFF;
          2:       w = 32'hFFFF_FFFF;
          3:       w = 32'h0000_0000;
          default: w = $urandom;
        endcase
        queue_request(op, w);
      end
    end

    // Drain: all requests taken, all results back, then a few spare cycles
    // to catch anything extra the block might still send.
    while (request_backlog.size() != 0 || in_valid || deque_replies_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && deque_replies_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
src/dq_pkg.sv
src/dq_cell.sv
src/bounded_double_ended_queue_top.sv
bench/bounded_double_ended_queue_top_tb.sv
